// ===== rtl/b58ptc_pkg.sv =====
// Package: payload types, status codes and character constants for the Base58 token compiler.
`timescale 1ns / 1ps
`default_nettype none

package b58ptc_pkg;

  localparam int unsigned NumSymbols = 58;

  localparam logic [NumSymbols-1:0] AllSymbols = {NumSymbols{1'b1}};

  localparam logic [2:0] StatToken    = 3'd0;
  localparam logic [2:0] StatUnsupOp  = 3'd1;
  localparam logic [2:0] StatNotB58   = 3'd2;
  localparam logic [2:0] StatEmptyCls = 3'd3;
  localparam logic [2:0] StatOpInCls  = 3'd4;
  localparam logic [2:0] StatUnclosed = 3'd5;

  localparam logic [7:0] ChAny      = 8'h3F;  // ?
  localparam logic [7:0] ChClsOpen  = 8'h5B;  // [
  localparam logic [7:0] ChClsClose = 8'h5D;  // ]

  typedef struct packed {
    logic [7:0] pattern_char;
    logic       end_of_pattern;
  } in_item_t;

  typedef struct packed {
    logic [NumSymbols-1:0] token_mask;
    logic [2:0]            status;
    logic                  final_result;
  } out_item_t;

  // Regex operators that are not supported outside a class
  function automatic logic is_operator(input logic [7:0] ch);
    logic hit;
    case (ch)
      8'h5D, 8'h2A, 8'h2B, 8'h7B, 8'h7D, 8'h28, 8'h29,
      8'h7C, 8'h2E, 8'h5E, 8'h24, 8'h5C: hit = 1'b1;
      default:                           hit = 1'b0;
    endcase
    return hit;
  endfunction

  // One-hot alphabet bit of a byte, zero when the byte is not Base58
  function automatic logic [NumSymbols-1:0] symbol_bit(input logic [7:0] ch);
    logic [5:0] idx;
    logic       hit;
    idx = '0;
    hit = 1'b1;
    if (ch >= 8'h31 && ch <= 8'h39)       idx = 6'(ch - 8'h31);         // 1..9
    else if (ch >= 8'h41 && ch <= 8'h48)  idx = 6'(ch - 8'h41 + 8'd9);  // A..H
    else if (ch >= 8'h4A && ch <= 8'h4E)  idx = 6'(ch - 8'h4A + 8'd17); // J..N
    else if (ch >= 8'h50 && ch <= 8'h5A)  idx = 6'(ch - 8'h50 + 8'd22); // P..Z
    else if (ch >= 8'h61 && ch <= 8'h6B)  idx = 6'(ch - 8'h61 + 8'd33); // a..k
    else if (ch >= 8'h6D && ch <= 8'h7A)  idx = 6'(ch - 8'h6D + 8'd44); // m..z
    else hit = 1'b0;
    return hit ? (NumSymbols'(1) << idx) : '0;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/b58ptc_lit_mask.sv =====
// Literal decoder: alphabet mask of one byte, with optional other-case letter.
`timescale 1ns / 1ps
`default_nettype none

module b58ptc_lit_mask (
  input  wire logic [7:0]                     ch,
  input  wire logic                           fold_case,
  output logic [b58ptc_pkg::NumSymbols-1:0]   mask
);

  logic                                 is_letter;
  logic [b58ptc_pkg::NumSymbols-1:0]    own_bit;
  logic [b58ptc_pkg::NumSymbols-1:0]    other_bit;

  assign is_letter = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
  assign own_bit   = b58ptc_pkg::symbol_bit(ch);
  // flipping bit 5 swaps ASCII case
  assign other_bit = b58ptc_pkg::symbol_bit(ch ^ 8'h20);
  assign mask      = own_bit | ((fold_case && is_letter) ? other_bit : '0);

endmodule

`default_nettype wire

// ===== rtl/base58_pattern_token_compiler.sv =====
// Top level: Base58 pattern token compiler with input and result registers.
`timescale 1ns / 1ps
`default_nettype none

// Takes one pattern byte per transfer and returns at most one result per byte: a 58-bit
// acceptance mask with status 0 for each finished token, or an error status. One byte is
// accepted every clock cycle while in_stall is low; a byte passes an input register and
// the decode logic and lands in the result register, from which its result is taken.
// in_stall rises only while the result register holds a result that out_stall keeps back.
// After an error result the block drops bytes silently up to and including the byte marked
// end_of_pattern, which returns the pattern state to idle. cfg_wr_en writes fold_case and is
// only to be used with no byte in flight.
module base58_pattern_token_compiler (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire b58ptc_pkg::in_item_t  in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output b58ptc_pkg::out_item_t      out_item,
  input  wire logic                  cfg_wr_en,
  input  wire logic                  cfg_wr_data
);

  localparam int unsigned NS = b58ptc_pkg::NumSymbols;

  logic                  fold_case_r;
  logic                  s1_valid_r;
  b58ptc_pkg::in_item_t  s1_item_r;
  logic                  out_valid_r, out_valid_nxt;
  b58ptc_pkg::out_item_t out_item_r;

  logic          in_cls_r, in_cls_nxt;
  logic [NS-1:0] accum_r, accum_nxt;
  logic          empty_r, empty_nxt;
  logic          has_op_r, has_op_nxt;
  logic          err_r, err_nxt;

  logic          s1_fire;
  logic          emit;
  logic [2:0]    status;
  logic [NS-1:0] mask;
  logic [NS-1:0] lit_mask;
  logic [7:0]    ch;
  logic          last;

  assign ch   = s1_item_r.pattern_char;
  assign last = s1_item_r.end_of_pattern;

  assign s1_fire  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_fire;

  b58ptc_lit_mask u_lit (
    .ch        (ch),
    .fold_case (fold_case_r),
    .mask      (lit_mask)
  );

  always_comb begin
    emit       = 1'b0;
    status     = b58ptc_pkg::StatToken;
    mask       = '0;
    in_cls_nxt = in_cls_r;
    accum_nxt  = accum_r;
    empty_nxt  = empty_r;
    has_op_nxt = has_op_r;
    err_nxt    = err_r;

    if (!err_r) begin
      if (in_cls_r) begin
        if (ch == b58ptc_pkg::ChClsClose) begin
          emit = 1'b1;
          if (empty_r)                status = b58ptc_pkg::StatEmptyCls;
          else if (has_op_r)          status = b58ptc_pkg::StatOpInCls;
          else if (accum_r == '0)     status = b58ptc_pkg::StatNotB58;
          else                        mask   = accum_r;
          in_cls_nxt = 1'b0;
        end else begin
          empty_nxt = 1'b0;
          if (ch == b58ptc_pkg::ChClsOpen || ch == b58ptc_pkg::ChAny) has_op_nxt = 1'b1;
          else                                                       accum_nxt  = accum_r | lit_mask;
          if (last) begin
            emit   = 1'b1;
            status = b58ptc_pkg::StatUnclosed;
          end
        end
      end else if (ch == b58ptc_pkg::ChAny) begin
        emit = 1'b1;
        mask = b58ptc_pkg::AllSymbols;
      end else if (ch == b58ptc_pkg::ChClsOpen) begin
        in_cls_nxt = 1'b1;
        accum_nxt  = '0;
        empty_nxt  = 1'b1;
        has_op_nxt = 1'b0;
        if (last) begin
          emit   = 1'b1;
          status = b58ptc_pkg::StatUnclosed;
        end
      end else if (b58ptc_pkg::is_operator(ch)) begin
        emit   = 1'b1;
        status = b58ptc_pkg::StatUnsupOp;
      end else begin
        emit = 1'b1;
        mask = lit_mask;
        if (lit_mask == '0) status = b58ptc_pkg::StatNotB58;
      end
    end

    if (last) begin
      in_cls_nxt = 1'b0;
      accum_nxt  = '0;
      empty_nxt  = 1'b1;
      has_op_nxt = 1'b0;
      err_nxt    = 1'b0;
    end else if (emit && status != b58ptc_pkg::StatToken) begin
      err_nxt = 1'b1;
    end
  end

  always_comb begin
    if (s1_fire && emit)   out_valid_nxt = 1'b1;
    else                   out_valid_nxt = out_valid_r && out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_case_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      in_cls_r    <= 1'b0;
      accum_r     <= '0;
      empty_r     <= 1'b1;
      has_op_r    <= 1'b0;
      err_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) fold_case_r <= cfg_wr_data;
      if (!in_stall) s1_valid_r <= in_valid;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        in_cls_r <= in_cls_nxt;
        accum_r  <= accum_nxt;
        empty_r  <= empty_nxt;
        has_op_r <= has_op_nxt;
        err_r    <= err_nxt;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) s1_item_r <= in_item;
    if (s1_fire && emit) begin
      out_item_r.token_mask   <= mask;
      out_item_r.status       <= status;
      out_item_r.final_result <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== bench/token_sb_pkg.sv =====
// Scoreboard class that predicts and checks the Base58 token compiler's results.
`timescale 1ns / 1ps

package token_sb_pkg;
  import b58ptc_pkg::*;

  // Symbol index i is character i, counted from the left
  localparam logic [8*58-1:0] B58_CHARS =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
  localparam logic [8*12-1:0] REGEX_OPS = "]*+{}()|.^$\\";

  class token_scoreboard;
    bit                    fold_case;
    bit                    in_class;
    bit                    class_empty;
    bit                    class_op;
    bit                    err_held;
    logic [NumSymbols-1:0] class_bits;
    out_item_t             expected_q[$];
    int unsigned           mismatches;
    int unsigned           live_bytes;

    function new();
      fold_case  = 1'b0;
      mismatches = 0;
      live_bytes = 0;
      clear_pattern();
    endfunction

    function void clear_pattern();
      in_class    = 1'b0;
      class_bits  = '0;
      class_empty = 1'b1;
      class_op    = 1'b0;
      err_held    = 1'b0;
    endfunction

    function logic [NumSymbols-1:0] alpha_bit(logic [7:0] ch);
      logic [NumSymbols-1:0] m;
      m = '0;
      for (int i = 0; i < NumSymbols; i++)
        if (B58_CHARS[8*(NumSymbols-1-i) +: 8] == ch) m[i] = 1'b1;
      return m;
    endfunction

    function logic [NumSymbols-1:0] char_accept_bits(logic [7:0] ch);
      logic [NumSymbols-1:0] m;
      m = alpha_bit(ch);
      if (fold_case) begin
        if (ch >= "a" && ch <= "z") m |= alpha_bit(ch - 8'd32);
        else if (ch >= "A" && ch <= "Z") m |= alpha_bit(ch + 8'd32);
      end
      return m;
    endfunction

    function bit is_regex_op(logic [7:0] ch);
      bit hit;
      hit = 1'b0;
      for (int i = 0; i < 12; i++)
        if (REGEX_OPS[8*i +: 8] == ch) hit = 1'b1;
      return hit;
    endfunction

    // Called for every input transfer
    function void note_byte(in_item_t it);
      out_item_t  r;
      bit         emit;
      logic [7:0] ch;
      ch = it.pattern_char;
      live_bytes++;
      if (err_held) begin
        if (it.end_of_pattern) clear_pattern();
        return;
      end
      emit           = 1'b0;
      r.token_mask   = '0;
      r.status       = StatToken;
      r.final_result = it.end_of_pattern;
      if (in_class) begin
        if (ch == ChClsClose) begin
          emit     = 1'b1;
          in_class = 1'b0;
          if (class_empty) r.status = StatEmptyCls;
          else if (class_op) r.status = StatOpInCls;
          else if (class_bits == '0) r.status = StatNotB58;
          else r.token_mask = class_bits;
        end else begin
          class_empty = 1'b0;
          if (ch == ChClsOpen || ch == ChAny) class_op = 1'b1;
          else class_bits |= char_accept_bits(ch);
          if (it.end_of_pattern) begin
            emit     = 1'b1;
            r.status = StatUnclosed;
          end
        end
      end else if (ch == ChAny) begin
        emit         = 1'b1;
        r.token_mask = AllSymbols;
      end else if (ch == ChClsOpen) begin
        in_class    = 1'b1;
        class_bits  = '0;
        class_empty = 1'b1;
        class_op    = 1'b0;
        if (it.end_of_pattern) begin
          emit     = 1'b1;
          r.status = StatUnclosed;
        end
      end else if (is_regex_op(ch)) begin
        emit     = 1'b1;
        r.status = StatUnsupOp;
      end else begin
        emit         = 1'b1;
        r.token_mask = char_accept_bits(ch);
        if (r.token_mask == '0) r.status = StatNotB58;
      end
      if (it.end_of_pattern) clear_pattern();
      else if (emit && r.status != StatToken) err_held = 1'b1;
      if (emit) expected_q.insert(expected_q.size(), r);
    endfunction

    // Called for every result transfer
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $error("result with none pending: token_mask %h status %0d final_result %0b",
               got.token_mask, got.status, got.final_result);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.token_mask !== want.token_mask) begin
        $error("token_mask: expected %h, got %h", want.token_mask, got.token_mask);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.final_result !== want.final_result) begin
        $error("final_result: expected %0b, got %0b", want.final_result, got.final_result);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== bench/testbench.sv =====
// Top of the bench: drives pattern bytes, stalls results and checks them on the scoreboard.
`timescale 1ns / 1ps

module testbench;
  import b58ptc_pkg::*;
  import token_sb_pkg::*;

  localparam int unsigned IdleLimit     = 5000;
  localparam int unsigned ItemsPerPhase = 225;
  localparam int unsigned NumDirected   = 25;

  // Hand-picked patterns; a set bit in DIRECTED_LAST marks the final byte
  localparam logic [8*NumDirected-1:0] DIRECTED_CHARS =
    {"1z?", "l", 8'hFF, "*A", "[", "[]", "[?a]", "[l0]", "[aZ]k", "[a"};
  localparam logic [NumDirected-1:0] DIRECTED_LAST = 25'b1_0100_0010_0010_0010_1101_1100;
  localparam logic [8*4-1:0] NON_B58 = "0OIl";

  typedef enum int unsigned {
    StallNone,
    StallCoin,
    StallHeavy,
    StallPeriodic
  } stall_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_wr_en;
  logic        cfg_wr_data;

  token_scoreboard sb;
  logic [7:0]      pat_q[$];
  int unsigned     burst_left;
  int unsigned     idle_cycles = 0;
  stall_mode_t     stall_mode = StallNone;
  int unsigned     stall_left = 0;
  int unsigned     stall_period = 2;
  int unsigned     stall_duty = 1;
  int unsigned     stall_phase = 0;
  logic            next_stall;

  base58_pattern_token_compiler uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_byte(in_item);
      if (out_valid && !out_stall) sb.check_result(out_item);
    end
  end

  // Receiver back-pressure: a new stall pattern is drawn whenever the current one runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode   = stall_mode_t'($urandom_range(0, 3));
      stall_left   = $urandom_range(20, 300);
      stall_period = $urandom_range(2, 12);
      stall_duty   = $urandom_range(1, stall_period - 1);
      stall_phase  = 0;
    end
    stall_left--;
    stall_phase = (stall_phase + 1) % stall_period;
    case (stall_mode)
      StallNone:  next_stall = 1'b0;
      StallCoin:  next_stall = $urandom_range(0, 1);
      StallHeavy: next_stall = ($urandom_range(0, 7) != 0);
      default:    next_stall = (stall_phase < stall_duty);
    endcase
    out_stall <= next_stall;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] ch, input logic last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_item  <= {ch, last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // Let every result arrive, then wait on for bytes that give none
  task automatic drain();
    in_valid <= 1'b0;
    // the last transfer is noted on the scoreboard at the edge just taken
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_fold(input logic v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.fold_case = v;
  endtask

  function automatic void queue_byte(input logic [7:0] ch);
    pat_q.insert(pat_q.size(), ch);
  endfunction

  function automatic logic [7:0] pick_literal();
    logic [7:0] ch;
    if ($urandom_range(0, 9) < 6) begin
      ch = B58_CHARS[8*$urandom_range(0, 57) +: 8];
    end else begin
      ch = 8'h41 + 8'($urandom_range(0, 25));
      if ($urandom_range(0, 1)) ch = ch + 8'h20;
    end
    return ch;
  endfunction

  // Mostly well-formed tokens, with noise, operators and broken classes mixed in
  task automatic random_pattern();
    int unsigned tokens;
    int unsigned kind;
    bit          open_end;
    pat_q.delete();
    open_end = 1'b0;
    tokens   = $urandom_range(1, 10);
    for (int t = 0; t < tokens && !open_end; t++) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        queue_byte(pick_literal());
      end else if (kind < 55) begin
        queue_byte(ChAny);
      end else if (kind < 80) begin
        queue_byte(ChClsOpen);
        repeat ($urandom_range(1, 5)) queue_byte(pick_literal());
        queue_byte(ChClsClose);
      end else if (kind < 87) begin
        queue_byte(8'($urandom_range(0, 255)));
      end else if (kind < 91) begin
        queue_byte(REGEX_OPS[8*$urandom_range(0, 11) +: 8]);
      end else if (kind < 97) begin
        queue_byte(ChClsOpen);
        case ($urandom_range(0, 2))
          0: ;
          1: begin
            queue_byte(pick_literal());
            queue_byte($urandom_range(0, 1) ? ChAny : ChClsOpen);
          end
          default: begin
            repeat ($urandom_range(1, 3)) begin
              if ($urandom_range(0, 1)) queue_byte(NON_B58[8*$urandom_range(0, 3) +: 8]);
              else queue_byte(8'($urandom_range(128, 255)));
            end
          end
        endcase
        queue_byte(ChClsClose);
      end else begin
        // class left open at the end of the pattern
        queue_byte(ChClsOpen);
        repeat ($urandom_range(0, 3)) queue_byte(pick_literal());
        open_end = 1'b1;
      end
    end
    foreach (pat_q[i]) send_byte(pat_q[i], i == pat_q.size() - 1);
  endtask

  initial begin
    int unsigned start_count;
    logic        fold_plan[6];
    sb          = new();
    fold_plan   = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    burst_left  = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < NumDirected; k++)
      send_byte(DIRECTED_CHARS[8*(NumDirected-1-k) +: 8], DIRECTED_LAST[k]);

    foreach (fold_plan[p]) begin
      drain();
      write_fold(fold_plan[p]);
      start_count = sb.live_bytes;
      while (sb.live_bytes - start_count < ItemsPerPhase) random_pattern();
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
